@@ sv/gpmlc_pkg.sv @@
// Shared types, codes and constants for the GPIO pin mode lock controller.
`default_nettype none

package gpmlc_pkg;

    localparam int PORT_WIDTH   = 8;
    localparam int DEF_NUM_PINS = 32;
    localparam int DEF_NUM_PORT = 4;
    // Widest pin space and port select the block supports.
    localparam int MASK_W       = 64;
    localparam int PIN_SEL_W    = 6;
    localparam int PORT_SEL_W   = 3;
    localparam int PAD_W        = 32;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 80;

    typedef enum logic [2:0] {
        OP_SET_DIR    = 3'd0,
        OP_WRITE_PIN  = 3'd1,
        OP_READ_PIN   = 3'd2,
        OP_WRITE_PORT = 3'd3,
        OP_READ_PORT  = 3'd4,
        OP_TOGGLE_PIN = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALREADY    = 3'd1,
        ST_PIN_RANGE  = 3'd2,
        ST_IS_INPUT   = 3'd3,
        ST_IS_OUTPUT  = 3'd4,
        ST_PORT_RANGE = 3'd5,
        ST_NOT_CONFIG = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [7:0]       pin_index;
        logic [7:0]       port_index;
        logic [7:0]       write_value;
        logic             direction;
        logic [PAD_W-1:0] pad_levels;
    } item_t;

    // Pin state, zero-extended to the widest pin space.
    typedef struct packed {
        logic [MASK_W-1:0] out_bits;
        logic [MASK_W-1:0] dir_bits;
        logic [MASK_W-1:0] cfg_bits;
    } pin_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_data;
        logic [31:0] output_levels;
        logic [31:0] direction_mask;
    } result_t;

endpackage

`default_nettype wire

@@ sv/gpmlc_exec.sv @@
// Operation decode, pin mode checks and pin state update for one transaction.
`default_nettype none

module gpmlc_exec
    import gpmlc_pkg::*;
#(
    parameter int NUM_PINS  = DEF_NUM_PINS,
    parameter int NUM_PORTS = DEF_NUM_PORT
)
(
    input  item_t      item,
    input  pin_state_t cur,
    output pin_state_t nxt,
    output result_t    result
);

    localparam logic [MASK_W-1:0] PIN_MASK =
        (NUM_PINS >= MASK_W) ? {MASK_W{1'b1}}
                             : ((MASK_W'(1) << NUM_PINS) - MASK_W'(1));

    logic                  pin_ok;
    logic                  port_ok;
    logic [PIN_SEL_W-1:0]  pin_sel;
    logic [PORT_SEL_W-1:0] port_sel;
    logic [PIN_SEL_W-1:0]  shift;
    logic [MASK_W-1:0]     pads_ext;
    logic                  is_cfg;
    logic                  is_out;
    status_t               status;
    logic [7:0]            rdata;

    assign pin_ok   = item.pin_index < 8'(NUM_PINS);
    assign port_ok  = item.port_index < 8'(NUM_PORTS);
    assign pin_sel  = item.pin_index[PIN_SEL_W-1:0];
    assign port_sel = item.port_index[PORT_SEL_W-1:0];
    assign shift    = PIN_SEL_W'(port_sel) * PIN_SEL_W'(PORT_WIDTH);
    assign pads_ext = MASK_W'(item.pad_levels);
    assign is_cfg   = cur.cfg_bits[pin_sel];
    assign is_out   = cur.dir_bits[pin_sel];

    always_comb
    begin
        nxt    = cur;
        status = ST_OK;
        rdata  = '0;
        case (item.operation)
            OP_SET_DIR:
            begin
                if (!pin_ok)
                    status = ST_PIN_RANGE;
                else if (is_cfg)
                    status = ST_ALREADY;
                else
                begin
                    nxt.cfg_bits[pin_sel] = 1'b1;
                    nxt.dir_bits[pin_sel] = item.direction;
                end
            end
            OP_WRITE_PIN:
            begin
                if (!pin_ok)
                    status = ST_PIN_RANGE;
                else if (!is_cfg)
                    status = ST_NOT_CONFIG;
                else if (!is_out)
                    status = ST_IS_INPUT;
                else
                    nxt.out_bits[pin_sel] = item.write_value[0];
            end
            OP_READ_PIN:
            begin
                if (!pin_ok)
                    status = ST_PIN_RANGE;
                else if (!is_cfg)
                    status = ST_NOT_CONFIG;
                else if (is_out)
                    status = ST_IS_OUTPUT;
                else
                    rdata = 8'(pads_ext[pin_sel]);
            end
            OP_WRITE_PORT:
            begin
                if (!port_ok)
                    status = ST_PORT_RANGE;
                else
                    nxt.out_bits[shift +: PORT_WIDTH] = item.write_value;
            end
            OP_READ_PORT:
            begin
                if (!port_ok)
                    status = ST_PORT_RANGE;
                else
                    rdata = pads_ext[shift +: PORT_WIDTH];
            end
            OP_TOGGLE_PIN:
            begin
                if (!pin_ok)
                    status = ST_PIN_RANGE;
                else
                    nxt.out_bits[pin_sel] = ~cur.out_bits[pin_sel];
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        // port writes may reach past the last pin
        nxt.out_bits = nxt.out_bits & PIN_MASK;
    end

    assign result.status         = status;
    assign result.read_data      = rdata;
    assign result.output_levels  = nxt.out_bits[31:0];
    assign result.direction_mask = nxt.dir_bits[31:0];

endmodule

`default_nettype wire

@@ sv/gpio_pin_mode_lock_controller_unit.sv @@
// Top level of the GPIO pin mode lock controller: stream ports, pin state, pipeline.
`default_nettype none

// GPIO controller for NUM_PORTS ports of eight pins, NUM_PINS pins in all; pin p
// sits at bit p of every mask. Each pin starts unconfigured; its direction can be
// set once and is then locked. Single-pin writes need an output pin and single-pin
// reads an input pin; port writes, port reads and toggles carry no mode check. Every
// input transaction yields exactly one output transaction with a status code, the
// read data (zero unless a read succeeded) and the output and direction masks as
// they stand after the operation. Timing: one transaction per clock sustained while
// the receiver keeps up. A transaction lands in the input register, is decoded
// against the pin state, and when the input stage advances the pin state is updated
// and the result registered at the output, raising tvalid. Back-pressure from the
// master side stalls the input register; no clearing pass is needed after reset.
module gpio_pin_mode_lock_controller_unit
    import gpmlc_pkg::*;
#(
    parameter int NUM_PINS  = DEF_NUM_PINS,
    parameter int NUM_PORTS = DEF_NUM_PORT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // operation[2:0], pin_index[10:3], port_index[18:11], write_value[26:19],
    // direction[27], pad_levels[59:28], zero fill[63:60]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[2:0], read_data[10:3], output_levels[42:11], direction_mask[74:43],
    // zero fill[79:75]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    // Input stage
    logic       in_valid_reg;
    item_t      item_reg;
    logic       advance;

    // Pin state
    logic [NUM_PINS-1:0] out_bits_reg;
    logic [NUM_PINS-1:0] dir_bits_reg;
    logic [NUM_PINS-1:0] cfg_bits_reg;
    pin_state_t          cur_state;
    pin_state_t          nxt_state;

    // Result stage
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    item_t      s_item;

    assign s_item.operation   = s_tdata[2:0];
    assign s_item.pin_index   = s_tdata[10:3];
    assign s_item.port_index  = s_tdata[18:11];
    assign s_item.write_value = s_tdata[26:19];
    assign s_item.direction   = s_tdata[27];
    assign s_item.pad_levels  = s_tdata[59:28];

    // Input stage moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cur_state.out_bits = MASK_W'(out_bits_reg);
    assign cur_state.dir_bits = MASK_W'(dir_bits_reg);
    assign cur_state.cfg_bits = MASK_W'(cfg_bits_reg);

    gpmlc_exec #(
        .NUM_PINS  (NUM_PINS),
        .NUM_PORTS (NUM_PORTS)
    ) u_exec (
        .item   (item_reg),
        .cur    (cur_state),
        .nxt    (nxt_state),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bits_reg  <= '0;
            dir_bits_reg  <= '0;
            cfg_bits_reg  <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_bits_reg  <= nxt_state.out_bits[NUM_PINS-1:0];
                dir_bits_reg  <= nxt_state.dir_bits[NUM_PINS-1:0];
                cfg_bits_reg  <= nxt_state.cfg_bits[NUM_PINS-1:0];
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= s_item;
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       result_reg.direction_mask,
                       result_reg.output_levels,
                       result_reg.read_data,
                       result_reg.status};

    // A pin can only be marked output once its direction has been locked.
    a_dir_needs_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        ((dir_bits_reg & ~cfg_bits_reg) == '0))
        else $error("direction bit set on unconfigured pin");

    // Locked pins stay locked.
    a_cfg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((cfg_bits_reg & $past(cfg_bits_reg)) == $past(cfg_bits_reg)))
        else $error("configured pin lost its lock");

    // A held transaction in the input stage is not dropped.
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a pending transaction");

    // Read data only accompanies a successful operation.
    a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[10:3] != 8'd0)) |-> (m_tdata[2:0] == ST_OK))
        else $error("read data returned with an error status");

endmodule

`default_nettype wire

@@ verif/gpio_pin_mode_lock_controller_unit_tb.sv @@
// Self-checking testbench for the GPIO pin mode lock controller stream block.
`default_nettype none

module gpio_pin_mode_lock_controller_unit_tb;
    import gpmlc_pkg::*;

    // Operation codes the block leaves unused; they must change nothing.
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    // Worst case per item is roughly a long sender gap plus a long receiver
    // stall plus latency; the limit leaves room for that on all 1625 items.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1600;
    // Receiver hold-off that backs the pipeline up into the input port.
    localparam int HOLD_AT_ITEMS = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 100;

    typedef enum logic [1:0] {
        PIN_UNSET = 2'd0,
        PIN_IN    = 2'd1,
        PIN_OUT   = 2'd2
    } pin_mode_e;

    // Tracks pin state, predicts each result and holds results still due.
    class gpio_result_tracker;
        pin_mode_e   modes [DEF_NUM_PINS];
        logic [31:0] dir_bits;
        logic [31:0] out_bits;
        result_t     pending_results [$];
        int          accepted;
        int          fail_count;

        function new();
            foreach (modes[i]) modes[i] = PIN_UNSET;
            dir_bits   = '0;
            out_bits   = '0;
            accepted   = 0;
            fail_count = 0;
        endfunction

        task report_mismatch(input string what);
            fail_count++;
            if (fail_count <= MAX_PRINTED)
                $display("mismatch: %s", what);
        endtask

        // Applies one operation to the tracked state and returns its result.
        function result_t predict_gpio_op(input item_t it);
            result_t   r;
            logic      pin_ok;
            logic      port_ok;
            logic [4:0] p;
            logic [1:0] q;
            pin_mode_e mode;
            r.status    = ST_OK;
            r.read_data = '0;
            pin_ok  = it.pin_index < DEF_NUM_PINS;
            port_ok = it.port_index < DEF_NUM_PORT;
            p       = it.pin_index[4:0];
            q       = it.port_index[1:0];
            mode    = pin_ok ? modes[p] : PIN_UNSET;
            case (it.operation)
                OP_SET_DIR: begin
                    if (!pin_ok)
                        r.status = ST_PIN_RANGE;
                    else if (mode != PIN_UNSET)
                        r.status = ST_ALREADY;
                    else
                    begin
                        modes[p]    = it.direction ? PIN_OUT : PIN_IN;
                        dir_bits[p] = it.direction;
                    end
                end
                OP_WRITE_PIN: begin
                    if (!pin_ok)
                        r.status = ST_PIN_RANGE;
                    else if (mode == PIN_UNSET)
                        r.status = ST_NOT_CONFIG;
                    else if (mode != PIN_OUT)
                        r.status = ST_IS_INPUT;
                    else
                        out_bits[p] = it.write_value[0];
                end
                OP_READ_PIN: begin
                    if (!pin_ok)
                        r.status = ST_PIN_RANGE;
                    else if (mode == PIN_UNSET)
                        r.status = ST_NOT_CONFIG;
                    else if (mode != PIN_IN)
                        r.status = ST_IS_OUTPUT;
                    else
                        r.read_data = {7'b0, it.pad_levels[p]};
                end
                OP_WRITE_PORT: begin
                    if (!port_ok)
                        r.status = ST_PORT_RANGE;
                    else
                        out_bits[q*PORT_WIDTH +: PORT_WIDTH] = it.write_value;
                end
                OP_READ_PORT: begin
                    if (!port_ok)
                        r.status = ST_PORT_RANGE;
                    else
                        r.read_data = it.pad_levels[q*PORT_WIDTH +: PORT_WIDTH];
                end
                OP_TOGGLE_PIN: begin
                    if (!pin_ok)
                        r.status = ST_PIN_RANGE;
                    else
                        out_bits[p] = ~out_bits[p];
                end
                default: ;
            endcase
            r.output_levels  = out_bits;
            r.direction_mask = dir_bits;
            return r;
        endfunction

        // Called for every input transaction taken by the block.
        function void note_transaction(input logic [IN_DATA_W-1:0] d);
            item_t it;
            it.operation   = d[2:0];
            it.pin_index   = d[10:3];
            it.port_index  = d[18:11];
            it.write_value = d[26:19];
            it.direction   = d[27];
            it.pad_levels  = d[59:28];
            pending_results.push_back(predict_gpio_op(it));
            accepted++;
        endfunction

        // Called for every output transaction; compares against the oldest one due.
        task check_result(input logic [OUT_DATA_W-1:0] d);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", d));
                return;
            end
            want = pending_results.pop_front();
            if (d[2:0] !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", d[2:0], want.status));
            if (d[10:3] !== want.read_data)
                report_mismatch($sformatf("read_data %h, want %h", d[10:3], want.read_data));
            if (d[42:11] !== want.output_levels)
                report_mismatch($sformatf("output_levels %h, want %h",
                                          d[42:11], want.output_levels));
            if (d[74:43] !== want.direction_mask)
                report_mismatch($sformatf("direction_mask %h, want %h",
                                          d[74:43], want.direction_mask));
            if (d[79:75] !== 5'b0)
                report_mismatch($sformatf("fill bits %b not zero", d[79:75]));
        endtask
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    gpio_result_tracker tracker = new();

    int cycle_count   = 0;
    int sink_stall    = 0;
    int sink_free_run = 0;
    bit hold_done     = 1'b0;
    int src_free_run  = 0;

    gpio_pin_mode_lock_controller_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitors sample pre-edge values: every driver updates with nonblocking
    // assignments, so reads right after the edge see the settled values.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.note_transaction(s_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gpio_pin_mode_lock_controller_unit_tb: FAIL");
            $finish;
        end
    end

    // Receiver: random ready with short stalls, rare long ones, free-running
    // stretches, and one long hold-off once enough transactions went in.
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall--;
        end
        else if (!hold_done && tracker.accepted >= HOLD_AT_ITEMS)
        begin
            hold_done  = 1'b1;
            sink_stall = HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_free_run > 0)
        begin
            m_tready <= 1'b1;
            sink_free_run--;
        end
        else if (r < 3)
        begin
            m_tready      <= 1'b1;
            sink_free_run = $urandom_range(20, 80);
        end
        else if (r < 70)
            m_tready <= 1'b1;
        else if (r < 97)
        begin
            m_tready   <= 1'b0;
            sink_stall = $urandom_range(0, 3);
        end
        else
        begin
            m_tready   <= 1'b0;
            sink_stall = $urandom_range(10, 40);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(input item_t it);
        return {4'b0, it.pad_levels, it.direction, it.write_value,
                it.port_index, it.pin_index, it.operation};
    endfunction

    // Gap after a transaction: valid drops only when the gap is nonzero, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic source_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (src_free_run > 0)
        begin
            src_free_run--;
            gap = 0;
        end
        else if (r < 3)
        begin
            src_free_run = $urandom_range(20, 80);
            gap = 0;
        end
        else if (r < 55)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_item(input item_t it);
        s_tdata  <= pack_item(it);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        source_gap();
    endtask

    task automatic push_op(input logic [2:0] op, input logic [7:0] pin,
                           input logic [7:0] port, input logic [7:0] wval,
                           input logic dir, input logic [31:0] pads);
        item_t it;
        it.operation   = op;
        it.pin_index   = pin;
        it.port_index  = port;
        it.write_value = wval;
        it.direction   = dir;
        it.pad_levels  = pads;
        push_item(it);
    endtask

    // Random operation, weighted toward the checked single-pin paths.
    task automatic push_random_op();
        int          r;
        logic [2:0]  op;
        logic [7:0]  pin;
        logic [7:0]  port;
        r = $urandom_range(0, 99);
        if (r < 15)      op = OP_SET_DIR;
        else if (r < 35) op = OP_WRITE_PIN;
        else if (r < 55) op = OP_READ_PIN;
        else if (r < 67) op = OP_WRITE_PORT;
        else if (r < 79) op = OP_READ_PORT;
        else if (r < 94) op = OP_TOGGLE_PIN;
        else if (r < 97) op = OP_RSVD_6;
        else             op = OP_RSVD_7;
        // Mostly legal pins and ports; the rest spans the whole byte.
        pin  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, DEF_NUM_PINS - 1))
                                           : 8'($urandom_range(0, 255));
        port = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, DEF_NUM_PORT - 1))
                                           : 8'($urandom_range(0, 255));
        push_op(op, pin, port, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                32'($urandom));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lock-once, access checks, range limits, toggles, ports.
        push_op(OP_READ_PIN,   8'd0,   8'd0,   8'h00, 1'b0, 32'hFFFF_FFFF); // unconfigured
        push_op(OP_WRITE_PIN,  8'd0,   8'd0,   8'h01, 1'b0, 32'h0);         // unconfigured
        push_op(OP_SET_DIR,    8'd0,   8'd0,   8'h00, 1'b1, 32'h0);         // pin 0 output
        push_op(OP_SET_DIR,    8'd0,   8'd0,   8'h00, 1'b0, 32'h0);         // already locked
        push_op(OP_WRITE_PIN,  8'd0,   8'd0,   8'hFF, 1'b0, 32'h0);         // drive high
        push_op(OP_WRITE_PIN,  8'd0,   8'd0,   8'hFE, 1'b0, 32'h0);         // bit 0 only
        push_op(OP_READ_PIN,   8'd0,   8'd0,   8'h00, 1'b0, 32'hFFFF_FFFF); // pin is output
        push_op(OP_SET_DIR,    8'd31,  8'd0,   8'h00, 1'b0, 32'h0);         // input clears bit
        push_op(OP_READ_PIN,   8'd31,  8'd0,   8'h00, 1'b0, 32'h8000_0000);
        push_op(OP_WRITE_PIN,  8'd31,  8'd0,   8'h01, 1'b1, 32'h0);         // pin is input
        push_op(OP_SET_DIR,    8'd32,  8'd0,   8'h00, 1'b1, 32'h0);         // just past range
        push_op(OP_SET_DIR,    8'd255, 8'd255, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_op(OP_TOGGLE_PIN, 8'd31,  8'd0,   8'h00, 1'b0, 32'h0);         // ignores mode
        push_op(OP_TOGGLE_PIN, 8'd200, 8'd0,   8'h00, 1'b0, 32'h0);
        push_op(OP_WRITE_PORT, 8'd0,   8'd3,   8'hA5, 1'b0, 32'h0);
        push_op(OP_WRITE_PORT, 8'd0,   8'd0,   8'hFF, 1'b0, 32'h0);
        push_op(OP_WRITE_PORT, 8'd0,   8'd4,   8'h5A, 1'b0, 32'h0);         // port past range
        push_op(OP_WRITE_PORT, 8'd0,   8'd255, 8'hFF, 1'b0, 32'h0);
        push_op(OP_READ_PORT,  8'd0,   8'd0,   8'h00, 1'b0, 32'hFFFF_FFFF);
        push_op(OP_READ_PORT,  8'd0,   8'd3,   8'h00, 1'b0, 32'h1234_5678);
        push_op(OP_READ_PORT,  8'd0,   8'd4,   8'h00, 1'b0, 32'hFFFF_FFFF);
        push_op(OP_RSVD_6,     8'd5,   8'd1,   8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_op(OP_RSVD_7,     8'd255, 8'd255, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_op(OP_SET_DIR,    8'd7,   8'd0,   8'h00, 1'b0, 32'h0);
        push_op(OP_READ_PIN,   8'd7,   8'd0,   8'h00, 1'b0, 32'h0000_0080);

        repeat (RANDOM_ITEMS) push_random_op();
        s_tvalid <= 1'b0;

        // Drain, then leave room for anything stray behind the last result.
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (tracker.fail_count == 0)
            $display("gpio_pin_mode_lock_controller_unit_tb: PASS");
        else
            $display("gpio_pin_mode_lock_controller_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
